>>> hdl/cube_face_triangle_index_splitter_assert.svh
// Assertion macros for the cube face triangle index splitter.
// Used by modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef CUBE_FACE_TRIANGLE_INDEX_SPLITTER_ASSERT_SVH
`define CUBE_FACE_TRIANGLE_INDEX_SPLITTER_ASSERT_SVH
`ifndef SYNTH
// plain property, checked on every clock edge outside reset
`define CFS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");
// same-cycle implication
`define CFS_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("%m: implication failed");
`else
`define CFS_ASSERT(lbl, prop)
`define CFS_ASSERT_IMP(lbl, pre, post)
`endif
`endif

>>> hdl/cfsplit_pkg.sv
// Shared types and constants of the cube face triangle index splitter.
// No dependencies.
`default_nettype none

package cfsplit_pkg;

  // field widths
  localparam int IdxW      = 12;
  localparam int GroupW    = 3;
  localparam int TolW      = 14;
  localparam int CoordW    = 16;
  localparam int PosW      = 3 * CoordW;

  // remap store geometry: one row of MaxVertices slots per group
  localparam int MaxVertices = 4096;
  localparam int GroupCount  = 7;
  localparam int CntW        = 13;
  localparam int RamDepth    = GroupCount * MaxVertices;
  localparam int RamAddrW    = GroupW + IdxW;

  // entry tag: a surface generation number, zero never matches a live one
  localparam int EpochW  = 8;
  localparam int EntryW  = EpochW + IdxW;

  // result queue
  localparam int ResDepth = 4;
  localparam int ResPtrW  = 2;
  localparam int ResCntW  = 3;

  localparam logic [GroupW-1:0] RegularGroup = 3'd6;
  localparam logic [TolW-1:0]   TolReset     = 14'd8;

  // one classified triangle waiting for renumbering
  typedef struct packed {
    logic                      start;
    logic [GroupW-1:0]         grp;
    logic [2:0][IdxW-1:0]      idx;
  } tri_t;

  // one renumbered corner
  typedef struct packed {
    logic [GroupW-1:0] grp;
    logic [IdxW-1:0]   src;
    logic [IdxW-1:0]   dst;
    logic              is_new;
    logic              last;
  } res_t;

  // remap store entry
  typedef struct packed {
    logic [EpochW-1:0] tag;
    logic [IdxW-1:0]   dest;
  } entry_t;

  // back part status toward the front part
  typedef struct packed {
    logic clearing;
    logic take;
  } back_stat_t;

endpackage

`default_nettype wire

>>> hdl/cfsplit_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cfsplit_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/cfsplit_front.sv
// Front part: tolerance register, face classification and a two-word triangle queue.
// Depends on cfsplit_pkg.
`default_nettype none

module cfsplit_front import cfsplit_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              surface_start_i,
  input  wire logic [IdxW-1:0]   corner_a_index_i,
  input  wire logic [IdxW-1:0]   corner_b_index_i,
  input  wire logic [IdxW-1:0]   corner_c_index_i,
  input  wire logic [PosW-1:0]   corner_a_position_i,
  input  wire logic [PosW-1:0]   corner_b_position_i,
  input  wire logic [PosW-1:0]   corner_c_position_i,
  input  wire logic              side_tolerance_we_i,
  input  wire logic [TolW-1:0]   side_tolerance_i,
  output tri_t                   head_o,
  output logic                   head_valid_o,
  input  wire back_stat_t        stat_i
);

  localparam int FaceW = 6;
  localparam logic signed [CoordW:0] BoundZero = 17'sd0;
  localparam logic signed [CoordW:0] BoundOne  = 17'sd8192;

  // |v - bound| == 0 or below the tolerance
  function automatic logic near_bound(input logic [CoordW-1:0] v,
                                      input logic signed [CoordW:0] bound,
                                      input logic [TolW-1:0] tol);
    logic signed [CoordW:0] d;
    logic [CoordW:0]        mag;
    d   = $signed({v[CoordW-1], v}) - bound;
    mag = d[CoordW] ? (CoordW+1)'(-d) : (CoordW+1)'(d);
    return (mag == '0) || (mag < {{(CoordW+1-TolW){1'b0}}, tol});
  endfunction

  // bit 2a: axis a near 0, bit 2a+1: axis a near 1
  function automatic logic [FaceW-1:0] face_mask(input logic [PosW-1:0] pos,
                                                 input logic [TolW-1:0] tol);
    logic [FaceW-1:0] m;
    m = '0;
    for (int a = 0; a < 3; a++) begin
      m[2*a]   = near_bound(pos[a*CoordW +: CoordW], BoundZero, tol);
      m[2*a+1] = near_bound(pos[a*CoordW +: CoordW], BoundOne, tol);
    end
    return m;
  endfunction

  logic [TolW-1:0] tol_q;
  tri_t            q_mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic [FaceW-1:0] mask_and;
  logic [GroupW-1:0] grp;
  tri_t            word_in;
  logic            accept;

  // tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (side_tolerance_we_i) begin
      tol_q <= side_tolerance_i;
    end
  end

  // classify: a single common face selects that face, else regular
  always_comb begin
    mask_and = face_mask(corner_a_position_i, tol_q)
             & face_mask(corner_b_position_i, tol_q)
             & face_mask(corner_c_position_i, tol_q);
    grp = RegularGroup;
    for (int s = 0; s < FaceW; s++) begin
      if (mask_and == (FaceW'(1) << s)) begin
        grp = GroupW'(s);
      end
    end
  end

  always_comb begin
    word_in.start  = surface_start_i;
    word_in.grp    = grp;
    word_in.idx[0] = corner_a_index_i;
    word_in.idx[1] = corner_b_index_i;
    word_in.idx[2] = corner_c_index_i;
  end

  // triangle queue
  assign full         = (cnt_q == 2'd2) || stat_i.clearing;
  assign accept       = push && !full;
  assign head_o       = q_mem_q[rd_ptr_q];
  assign head_valid_o = (cnt_q != 2'd0);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_mem_q[wr_ptr_q] <= word_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (stat_i.take) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(accept) - 2'(stat_i.take);
    end
  end

endmodule

`default_nettype wire

>>> hdl/cfsplit_res_fifo.sv
// Result queue: four corner words between the back part and the output ports.
// Depends on cfsplit_pkg.
`default_nettype none

module cfsplit_res_fifo import cfsplit_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire res_t         data_i,
  output logic [ResCntW-1:0] count_o,
  output logic              empty_o,
  input  wire logic         pop_i,
  output res_t              data_o
);

  res_t               mem_q [ResDepth];
  logic [ResPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [ResCntW-1:0] cnt_q;
  logic               take;

  assign empty_o = (cnt_q == '0);
  assign take    = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (take) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + ResCntW'(push_i) - ResCntW'(take);
    end
  end

endmodule

`default_nettype wire

>>> hdl/cfsplit_back.sv
// Back part: per-corner remap lookup and update on the remap RAM, group counters,
// clearing sweep. Depends on cfsplit_pkg, cfsplit_ram and the assertion macros.
`default_nettype none
`include "cube_face_triangle_index_splitter_assert.svh"

module cfsplit_back import cfsplit_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tri_t          head_i,
  input  wire logic          head_valid_i,
  output back_stat_t         stat_o,
  output res_t               res_o,
  output logic               res_push_o,
  input  wire logic [ResCntW-1:0] res_count_i
);

  localparam logic [0:0] ST_CLEAR = 1'b0;
  localparam logic [0:0] ST_RUN   = 1'b1;
  localparam logic [EpochW-1:0] EpochMax = '1;
  localparam logic [RamAddrW-1:0] ClrLast = RamAddrW'(RamDepth - 1);

  logic [0:0]          state_q;
  logic [RamAddrW-1:0] clr_addr_q;
  logic [EpochW-1:0]   epoch_q;
  logic [1:0]          corner_q;
  logic [CntW-1:0]     cnt_q [GroupCount];
  logic [CntW-1:0]     cnt_d [GroupCount];

  // lookup stage
  logic                w_valid_q, w_start_q, w_last_q;
  logic [GroupW-1:0]   w_grp_q;
  logic [IdxW-1:0]     w_src_q;
  logic [RamAddrW-1:0] w_addr_q;

  // last RAM write, covers the read-before-write of back-to-back corners
  logic                byp_valid_q;
  logic [RamAddrW-1:0] byp_addr_q;
  entry_t              byp_data_q;

  logic                wrap_pend, credit_ok, issue, go_clear;
  logic [IdxW-1:0]     cur_src;
  logic [RamAddrW-1:0] raddr;
  logic [EntryW-1:0]   ram_rdata;
  logic                ram_we;
  logic [RamAddrW-1:0] ram_waddr;
  entry_t              ram_wdata;
  logic [EpochW-1:0]   eff_epoch;
  entry_t              entry_rd;
  logic                hit;
  logic [CntW-1:0]     cnt_sel;
  logic                cnt_full;
  logic [IdxW-1:0]     dst;
  logic                is_new;

  // issue side: one corner of the head triangle per cycle, held while the result queue lacks room or a sweep is due
  assign wrap_pend = head_valid_i && (corner_q == 2'd0) && head_i.start
                     && (epoch_q == EpochMax);
  assign credit_ok = ((ResCntW+1)'(res_count_i) + (ResCntW+1)'(w_valid_q))
                     < (ResCntW+1)'(ResDepth);
  assign issue     = (state_q == ST_RUN) && head_valid_i && credit_ok && !wrap_pend;
  assign go_clear  = (state_q == ST_RUN) && wrap_pend && !w_valid_q;
  assign cur_src   = head_i.idx[corner_q];
  assign raddr     = {head_i.grp, cur_src};

  assign stat_o.take     = issue && (corner_q == 2'd2);
  assign stat_o.clearing = (state_q == ST_CLEAR);

  // lookup side: resolve hit or allocate
  always_comb begin
    eff_epoch = w_start_q ? epoch_q + 1'b1 : epoch_q;
    entry_rd  = (byp_valid_q && (byp_addr_q == w_addr_q)) ? byp_data_q
                                                          : entry_t'(ram_rdata);
    hit       = (entry_rd.tag == eff_epoch);
    cnt_sel   = w_start_q ? '0 : cnt_q[w_grp_q];
    cnt_full  = (cnt_sel >= CntW'(MaxVertices));
    if (hit) begin
      dst    = entry_rd.dest;
      is_new = 1'b0;
    end else begin
      dst    = cnt_full ? IdxW'(MaxVertices - 1) : cnt_sel[IdxW-1:0];
      is_new = 1'b1;
    end
  end

  // counter update: surface start clears every group first
  always_comb begin
    for (int g = 0; g < GroupCount; g++) begin
      cnt_d[g] = cnt_q[g];
      if (w_valid_q && w_start_q) begin
        cnt_d[g] = '0;
      end
    end
    if (w_valid_q && !hit && !cnt_full) begin
      cnt_d[w_grp_q] = cnt_sel + 1'b1;
    end
  end

  // RAM write: sweep while clearing, else the resolved entry
  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we         = w_valid_q;
      ram_waddr      = w_addr_q;
      ram_wdata.tag  = eff_epoch;
      ram_wdata.dest = dst;
    end
  end

  cfsplit_ram #(
    .Width (EntryW),
    .Depth (RamDepth)
  ) u_remap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // result word
  assign res_push_o    = w_valid_q;
  assign res_o.grp     = w_grp_q;
  assign res_o.src     = w_src_q;
  assign res_o.dst     = dst;
  assign res_o.is_new  = is_new;
  assign res_o.last    = w_last_q;

  // sequencer, generation number and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      epoch_q    <= '0;
      corner_q   <= 2'd0;
      w_valid_q  <= 1'b0;
      for (int g = 0; g < GroupCount; g++) begin
        cnt_q[g] <= '0;
      end
    end else begin
      w_valid_q <= issue;
      if (issue) begin
        corner_q <= (corner_q == 2'd2) ? 2'd0 : corner_q + 2'd1;
      end
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == ClrLast) begin
          state_q    <= ST_RUN;
          clr_addr_q <= '0;
          epoch_q    <= EpochW'(1);
        end
        for (int g = 0; g < GroupCount; g++) begin
          cnt_q[g] <= '0;
        end
      end else begin
        if (go_clear) begin
          state_q <= ST_CLEAR;
        end
        if (w_valid_q) begin
          epoch_q <= eff_epoch;
        end
        for (int g = 0; g < GroupCount; g++) begin
          cnt_q[g] <= cnt_d[g];
        end
      end
    end
  end

  // lookup stage payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      w_start_q <= head_i.start && (corner_q == 2'd0);
      w_last_q  <= (corner_q == 2'd2);
      w_grp_q   <= head_i.grp;
      w_src_q   <= cur_src;
      w_addr_q  <= raddr;
    end
  end

  // write bypass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_valid_q <= 1'b0;
    end else if (ram_we) begin
      byp_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      byp_addr_q <= ram_waddr;
      byp_data_q <= ram_wdata;
    end
  end

  // checks
  `CFS_ASSERT_IMP(a_clear_idle_stage, state_q == ST_CLEAR, !w_valid_q)
  `CFS_ASSERT_IMP(a_run_epoch_live, state_q == ST_RUN, epoch_q != '0)
  `CFS_ASSERT_IMP(a_cnt_bound, w_valid_q, cnt_sel <= CntW'(MaxVertices))
  `CFS_ASSERT_IMP(a_res_room, w_valid_q, res_count_i < ResCntW'(ResDepth))
  `CFS_ASSERT(a_take_last, stat_o.take |=> (w_valid_q && w_last_q))

endmodule

`default_nettype wire

>>> hdl/cube_face_triangle_index_splitter.sv
// Top level of the cube face triangle index splitter: front, back and result queue.
// Depends on cfsplit_pkg, cfsplit_front, cfsplit_back and cfsplit_res_fifo.
//
//   channel         handshake                   words
//   triangle in     push / full                 surface start, 3 indices, 3 positions
//   corner out      empty / pop                 group, source, dest, is_new, last
//   tolerance       side_tolerance_we_i         14-bit side tolerance, no read-back
//
// The back part issues one corner per cycle while the result queue has room, through
// the remap RAM's single read and write ports; each corner passes the lookup stage
// register into the result queue. After reset a clearing sweep of all 28672 RAM entries
// runs with full high; the same sweep runs again before a surface start that would
// exhaust the 8-bit entry generation (the 255th surface start after reset, then every
// 254th). The result queue holds four corners; without room beyond the corner in
// flight, the back part stops issuing and the two-word triangle queue absorbs input.
`default_nettype none

module cube_face_triangle_index_splitter import cfsplit_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              surface_start_i,
  input  wire logic [IdxW-1:0]   corner_a_index_i,
  input  wire logic [IdxW-1:0]   corner_b_index_i,
  input  wire logic [IdxW-1:0]   corner_c_index_i,
  input  wire logic [PosW-1:0]   corner_a_position_i,
  input  wire logic [PosW-1:0]   corner_b_position_i,
  input  wire logic [PosW-1:0]   corner_c_position_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic [GroupW-1:0]      group_o,
  output logic [IdxW-1:0]        source_index_o,
  output logic [IdxW-1:0]        dest_index_o,
  output logic                   is_new_o,
  output logic                   last_o,
  input  wire logic              side_tolerance_we_i,
  input  wire logic [TolW-1:0]   side_tolerance_i
);

  tri_t               head;
  logic               head_valid;
  back_stat_t         stat;
  res_t               res_in, res_out;
  logic               res_push;
  logic [ResCntW-1:0] res_count;

  // classification and triangle queue
  cfsplit_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push                (push),
    .full                (full),
    .surface_start_i     (surface_start_i),
    .corner_a_index_i    (corner_a_index_i),
    .corner_b_index_i    (corner_b_index_i),
    .corner_c_index_i    (corner_c_index_i),
    .corner_a_position_i (corner_a_position_i),
    .corner_b_position_i (corner_b_position_i),
    .corner_c_position_i (corner_c_position_i),
    .side_tolerance_we_i (side_tolerance_we_i),
    .side_tolerance_i    (side_tolerance_i),
    .head_o              (head),
    .head_valid_o        (head_valid),
    .stat_i              (stat)
  );

  // renumbering
  cfsplit_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .stat_o       (stat),
    .res_o        (res_in),
    .res_push_o   (res_push),
    .res_count_i  (res_count)
  );

  // output queue
  cfsplit_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .count_o (res_count),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (res_out)
  );

  assign group_o        = res_out.grp;
  assign source_index_o = res_out.src;
  assign dest_index_o   = res_out.dst;
  assign is_new_o       = res_out.is_new;
  assign last_o         = res_out.last;

endmodule

`default_nettype wire
